// ===== hw/rtl/rvaa_pkg.sv =====
// Package for the principal-axis vector rotator: widths, axis and quadrant
// codes, arctangent table and CORDIC gain constant. No dependencies.
`timescale 1ns / 1ps

package rvaa_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 8;

	// datapath widths
	localparam int CW      = COORD_WIDTH + GUARD_BITS + 3;
	localparam int EXT_W   = CW - COORD_WIDTH - 1 - GUARD_BITS;
	localparam int ZW      = 34;
	localparam int ZSHIFT  = 32 - ANGLE_WIDTH;
	localparam int HI_W    = CW - 32;
	localparam int Q1W     = CW + 1;
	localparam int Q2W     = Q1W + 1 - GUARD_BITS;
	localparam int NST     = CORDIC_STAGES + 5;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef enum logic [1:0] {
		QTR_0   = 2'd0,
		QTR_90  = 2'd1,
		QTR_180 = 2'd2,
		QTR_270 = 2'd3
	} qtr_t;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN32 [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// unsigned quotient by shift and subtract, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// CORDIC gain 1/An in Q32, evaluated at elaboration
	function automatic logic [63:0] gain_q32();
		logic [63:0] k2;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bit_v;
		k2 = 64'd1 << 62;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
		end
		n     = k2 << 2;
		res   = 64'd0;
		bit_v = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (n >= res + bit_v) begin
				n   = n - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	localparam logic [31:0] K_Q32 = 32'(gain_q32());

	typedef struct packed {
		axis_t                          axis;
		logic signed [COORD_WIDTH-1:0]  w;
		logic signed [COORD_WIDTH-1:0]  raw_u;
		logic signed [COORD_WIDTH-1:0]  raw_v;
	} side_t;

	typedef struct packed {
		side_t                 side;
		logic signed [CW-1:0]  u;
		logic signed [CW-1:0]  v;
		logic signed [ZW-1:0]  z;
	} cor_t;

endpackage

// ===== hw/rtl/rotate_vector_about_axis.sv =====
// Rotates a Q16.16 vector about X, Y or Z by a 16-bit binary angle.
// Quadrant fold, unrolled CORDIC, gain multiply and saturation. Uses rvaa_pkg.
`timescale 1ns / 1ps

// One vector per cycle while out_ready is high, through one input
// stage for the quadrant fold, one register stage per CORDIC iteration, then
// magnitude, gain multiply, rounding and saturation stages. Each stage loads
// whenever it is empty or its successor loads, so bubbles close up and the
// input takes transfers while a finished result waits on out_ready, until
// every stage holds an item. Axis code 3 passes the vector through unchanged.
module rotate_vector_about_axis
	import rvaa_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     axis,
	input  logic [ANGLE_WIDTH-1:0]         angle,
	input  logic signed [COORD_WIDTH-1:0]  x_in,
	input  logic signed [COORD_WIDTH-1:0]  y_in,
	input  logic signed [COORD_WIDTH-1:0]  z_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [COORD_WIDTH-1:0]  x_out,
	output logic signed [COORD_WIDTH-1:0]  y_out,
	output logic signed [COORD_WIDTH-1:0]  z_out
);

	localparam logic [ANGLE_WIDTH-1:0] EIGHTH = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 3);
	localparam logic [Q1W:0]           RND    = (Q1W + 1)'(1) << (GUARD_BITS - 1);
	localparam logic [Q2W-1:0]         LIM_P  = Q2W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic [Q2W-1:0]         LIM_N  = Q2W'(64'd1 << (COORD_WIDTH - 1));

	logic [NST-1:0] vld;
	logic [NST:0]   ld;

	// stage registers
	logic                          vld_s1;
	cor_t                          cor_s1;
	logic                          vld_s2 [CORDIC_STAGES];
	cor_t                          cor_s2 [CORDIC_STAGES];
	logic                          vld_s3, vld_s4, vld_s5, vld_s6;
	side_t                         side_s3, side_s4, side_s5;
	logic                          neg_s3 [2];
	logic                          neg_s4 [2];
	logic                          neg_s5 [2];
	logic [CW-1:0]                 mag_s3 [2];
	logic [63:0]                   lo_s4  [2];
	logic [HI_W+31:0]              hi_s4  [2];
	logic [Q1W-1:0]                q1_s5  [2];

	// load enables: a stage loads when empty or when its successor loads
	assign ld[NST] = out_ready;
	for (genvar k = 0; k < NST; k++) begin : g_ld
		assign ld[k] = !vld[k] || ld[k+1];
	end

	assign vld[0] = vld_s1;
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vld
		assign vld[1+i] = vld_s2[i];
	end
	assign vld[CORDIC_STAGES+1] = vld_s3;
	assign vld[CORDIC_STAGES+2] = vld_s4;
	assign vld[CORDIC_STAGES+3] = vld_s5;
	assign vld[CORDIC_STAGES+4] = vld_s6;

	assign in_ready  = ld[0];
	assign out_valid = vld_s6;

	// stage 1: pair select, quadrant fold, guard scaling
	logic signed [COORD_WIDTH-1:0] sel_u, sel_v, sel_w;
	logic [ANGLE_WIDTH-1:0]        qa, res_ang;
	qtr_t                          qtr;
	logic signed [COORD_WIDTH:0]   pu, pv, eu, ev;
	cor_t                          cor_d1;

	always_comb begin
		case (axis_t'(axis))
			AXIS_X: begin
				sel_u = y_in;
				sel_v = z_in;
				sel_w = x_in;
			end
			AXIS_Y: begin
				sel_u = z_in;
				sel_v = x_in;
				sel_w = y_in;
			end
			default: begin
				sel_u = x_in;
				sel_v = y_in;
				sel_w = z_in;
			end
		endcase

		qa      = angle + EIGHTH;
		qtr     = qtr_t'(qa[ANGLE_WIDTH-1 -: 2]);
		res_ang = angle - {qa[ANGLE_WIDTH-1 -: 2], {(ANGLE_WIDTH - 2){1'b0}}};

		eu = {sel_u[COORD_WIDTH-1], sel_u};
		ev = {sel_v[COORD_WIDTH-1], sel_v};
		case (qtr)
			QTR_90: begin
				pu = -ev;
				pv = eu;
			end
			QTR_180: begin
				pu = -eu;
				pv = -ev;
			end
			QTR_270: begin
				pu = ev;
				pv = -eu;
			end
			default: begin
				pu = eu;
				pv = ev;
			end
		endcase

		cor_d1.side.axis  = axis_t'(axis);
		cor_d1.side.w     = sel_w;
		cor_d1.side.raw_u = sel_u;
		cor_d1.side.raw_v = sel_v;
		cor_d1.u = {{EXT_W{pu[COORD_WIDTH]}}, pu, {GUARD_BITS{1'b0}}};
		cor_d1.v = {{EXT_W{pv[COORD_WIDTH]}}, pv, {GUARD_BITS{1'b0}}};
		cor_d1.z = {{(ZW - 32){res_ang[ANGLE_WIDTH-1]}}, res_ang, {ZSHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld[0]) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0] && in_valid) begin
			cor_s1 <= cor_d1;
		end
	end

	// CORDIC iterations, one per register stage
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		localparam logic signed [ZW-1:0] ATZ = $signed(ZW'(ATAN_TURN32[i]));
		cor_t prev;
		cor_t nxt;
		logic prev_vld;

		if (i == 0) begin : g_first
			assign prev     = cor_s1;
			assign prev_vld = vld_s1;
		end else begin : g_next
			assign prev     = cor_s2[i-1];
			assign prev_vld = vld_s2[i-1];
		end

		always_comb begin
			nxt = prev;
			if (!prev.z[ZW-1]) begin
				nxt.u = $signed(prev.u) - ($signed(prev.v) >>> i);
				nxt.v = $signed(prev.v) + ($signed(prev.u) >>> i);
				nxt.z = $signed(prev.z) - ATZ;
			end else begin
				nxt.u = $signed(prev.u) + ($signed(prev.v) >>> i);
				nxt.v = $signed(prev.v) - ($signed(prev.u) >>> i);
				nxt.z = $signed(prev.z) + ATZ;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[i] <= 1'b0;
			end else if (ld[i+1]) begin
				vld_s2[i] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[i+1] && prev_vld) begin
				cor_s2[i] <= nxt;
			end
		end
	end

	// stage 3: sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld[CORDIC_STAGES+1]) begin
				vld_s3 <= vld_s2[CORDIC_STAGES-1];
			end
			if (ld[CORDIC_STAGES+2]) begin
				vld_s4 <= vld_s3;
			end
			if (ld[CORDIC_STAGES+3]) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[CORDIC_STAGES+1] && vld_s2[CORDIC_STAGES-1]) begin
			side_s3   <= cor_s2[CORDIC_STAGES-1].side;
			neg_s3[0] <= cor_s2[CORDIC_STAGES-1].u[CW-1];
			neg_s3[1] <= cor_s2[CORDIC_STAGES-1].v[CW-1];
			mag_s3[0] <= cor_s2[CORDIC_STAGES-1].u[CW-1] ?
				-cor_s2[CORDIC_STAGES-1].u : cor_s2[CORDIC_STAGES-1].u;
			mag_s3[1] <= cor_s2[CORDIC_STAGES-1].v[CW-1] ?
				-cor_s2[CORDIC_STAGES-1].v : cor_s2[CORDIC_STAGES-1].v;
		end
		// stage 4: gain multiply, magnitude split at bit 32 into two partial products
		if (ld[CORDIC_STAGES+2] && vld_s3) begin
			side_s4 <= side_s3;
			for (int l = 0; l < 2; l++) begin
				neg_s4[l] <= neg_s3[l];
				lo_s4[l]  <= mag_s3[l][31:0] * K_Q32;
				hi_s4[l]  <= mag_s3[l][CW-1:32] * K_Q32;
			end
		end
		// stage 5: combine partials, round off 32 bits
		if (ld[CORDIC_STAGES+3] && vld_s4) begin
			side_s5 <= side_s4;
			for (int l = 0; l < 2; l++) begin
				neg_s5[l] <= neg_s4[l];
				q1_s5[l]  <= Q1W'(hi_s4[l]) + Q1W'(lo_s4[l][63:32]) + Q1W'(lo_s4[l][31]);
			end
		end
	end

	// stage 6: drop guard bits, saturate, map back to x/y/z
	logic [Q1W:0]                  q1r  [2];
	logic [Q2W-1:0]                q2   [2];
	logic [Q2W-1:0]                smag [2];
	logic signed [COORD_WIDTH-1:0] lane [2];
	logic signed [COORD_WIDTH-1:0] xo_d, yo_d, zo_d;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			q1r[l] = {1'b0, q1_s5[l]} + RND;
			q2[l]  = q1r[l][Q1W:GUARD_BITS];
			if (neg_s5[l]) begin
				smag[l] = (q2[l] > LIM_N) ? LIM_N : q2[l];
				lane[l] = -COORD_WIDTH'(smag[l]);
			end else begin
				smag[l] = (q2[l] > LIM_P) ? LIM_P : q2[l];
				lane[l] = COORD_WIDTH'(smag[l]);
			end
		end
		if (side_s5.axis == AXIS_NONE) begin
			lane[0] = side_s5.raw_u;
			lane[1] = side_s5.raw_v;
		end
		case (side_s5.axis)
			AXIS_X: begin
				xo_d = side_s5.w;
				yo_d = lane[0];
				zo_d = lane[1];
			end
			AXIS_Y: begin
				xo_d = lane[1];
				yo_d = side_s5.w;
				zo_d = lane[0];
			end
			default: begin
				xo_d = lane[0];
				yo_d = lane[1];
				zo_d = side_s5.w;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (ld[CORDIC_STAGES+4]) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[CORDIC_STAGES+4] && vld_s5) begin
			x_out <= xo_d;
			y_out <= yo_d;
			z_out <= zo_d;
		end
	end

	// accepted transfer always lands in the first stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted transfer not captured in stage 1");

	// back pressure reaches the input only when every stage holds an item
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld)
		else $error("input stalled with a bubble in the pipeline");

	// CORDIC headroom: magnitudes never reach the datapath sign bit
	a_headroom: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> !mag_s3[0][CW-1] && !mag_s3[1][CW-1])
		else $error("CORDIC datapath overflow");

endmodule
